FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file cmw_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk_i, switched off while rst_ni is low.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property checked at every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

FILE: rtl/core/cmw_pkg.sv
// Types and constants of the column melt wipe engine.
package cmw_pkg;

  localparam int unsigned REQ_TYPE_W = 2;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned RND_W      = 8;
  localparam int unsigned TICK_W     = 4;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned OFF_W      = 11;
  localparam int unsigned SEED_W     = 5;
  localparam int unsigned ACOL_W     = 9;
  localparam int unsigned HEIGHT_W   = 10;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_ACTIVE_COLUMNS = 1'b0;
  localparam logic REG_SCREEN_HEIGHT  = 1'b1;

  localparam logic [ACOL_W-1:0]   ACTIVE_COLUMNS_RST = 9'd160;
  localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST  = 10'd200;

  // Melt arithmetic
  localparam int FAST_LIMIT = 16;   // below this an offset doubles plus one
  localparam int SLOW_STEP  = 8;    // fixed fall from then on
  localparam int SEED_FLOOR = -15;  // lowest seed offset
  localparam int SEED_MIN   = -16;  // walk value folded onto the floor

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_SEED  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  // Classified item passed from front to back
  typedef struct packed {
    req_type_e                 kind;
    logic                      col_ok;    // column lies inside the store
    logic signed [SEED_W-1:0]  seed_val;
    logic [COL_W-1:0]          col;
    logic [TICK_W-1:0]         ticks;
    logic [ROW_W-1:0]          row;
  } cmd_t;

  typedef struct packed {
    logic              use_end_frame;
    logic [ROW_W-1:0]  source_row;
    logic              all_done;
  } rsp_t;

  typedef struct packed {
    logic [ACOL_W-1:0]   active_columns;
    logic [HEIGHT_W-1:0] screen_height;
  } cfg_t;

  // x mod 3 from the sum of its base-4 digits
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] x);
    logic [3:0] s;
    logic [1:0] r;
    s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
      default:                       r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/cmw_req_if.sv
// Request channel of the column melt wipe engine.
interface cmw_req_if;
  logic                            valid;
  logic                            ready;
  logic [cmw_pkg::REQ_TYPE_W-1:0]  req_type;
  logic [cmw_pkg::COL_W-1:0]       column_index;
  logic [cmw_pkg::RND_W-1:0]       random_byte;
  logic [cmw_pkg::TICK_W-1:0]      tick_count;
  logic [cmw_pkg::ROW_W-1:0]       row_index;

  modport source (
    output valid, req_type, column_index, random_byte, tick_count, row_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, column_index, random_byte, tick_count, row_index,
    output ready
  );
endinterface

FILE: rtl/core/cmw_rsp_if.sv
// Result channel of the column melt wipe engine.
interface cmw_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       use_end_frame;
  logic [cmw_pkg::ROW_W-1:0]  source_row;
  logic                       all_done;

  modport source (
    output valid, use_end_frame, source_row, all_done,
    input  ready
  );
  modport sink (
    input  valid, use_end_frame, source_row, all_done,
    output ready
  );
endinterface

FILE: rtl/core/cmw_front.sv
// Front end: accepts items, classifies them and works out seed offsets.
module cmw_front #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cmw_req_if.sink        req_i,
  output cmw_pkg::cmd_t  cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);

  logic signed [cmw_pkg::SEED_W-1:0] prev_seed_q, prev_seed_d;
  logic signed [cmw_pkg::SEED_W-1:0] seed_val;
  logic signed [cmw_pkg::SEED_W:0]   walk;
  cmw_pkg::req_type_e                kind;
  logic                              col_ok;
  logic                              accept;

  assign kind        = cmw_pkg::req_type_e'(req_i.req_type);
  assign col_ok      = 32'(req_i.column_index) < 32'(MAX_COLUMNS);
  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;
  assign accept      = req_i.valid && cmd_ready_i;

  // previous seed plus a step of -1, 0 or +1
  assign walk = {prev_seed_q[cmw_pkg::SEED_W-1], prev_seed_q}
              + (cmw_pkg::SEED_W + 1)'(cmw_pkg::mod3(req_i.random_byte))
              - (cmw_pkg::SEED_W + 1)'(1);

  always_comb begin
    if (req_i.column_index == '0) begin
      seed_val = -$signed({1'b0, req_i.random_byte[3:0]});
    end else if (walk > 0) begin
      seed_val = '0;
    end else if (walk == (cmw_pkg::SEED_W + 1)'(cmw_pkg::SEED_MIN)) begin
      seed_val = cmw_pkg::SEED_W'(cmw_pkg::SEED_FLOOR);
    end else begin
      seed_val = walk[cmw_pkg::SEED_W-1:0];
    end
  end

  always_comb begin
    cmd_o.kind     = kind;
    cmd_o.col_ok   = col_ok;
    cmd_o.seed_val = seed_val;
    cmd_o.col      = req_i.column_index;
    cmd_o.ticks    = req_i.tick_count;
    cmd_o.row      = req_i.row_index;
  end

  assign prev_seed_d = (accept && kind == cmw_pkg::REQ_SEED && col_ok) ? seed_val
                                                                        : prev_seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_seed_q <= '0;
    end else begin
      prev_seed_q <= prev_seed_d;
    end
  end

endmodule

FILE: rtl/core/cmw_queue.sv
// Short command queue between front and back end.
module cmw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmw_pkg::cmd_t  push_data_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output cmw_pkg::cmd_t  pop_data_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);

  cmw_pkg::cmd_t                entry_q [cmw_pkg::QUEUE_DEPTH];
  logic [cmw_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [cmw_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [cmw_pkg::QCNT_W-1:0]   cnt_q, cnt_d;
  logic                         push, pop;

  assign push_ready_o = cnt_q != cmw_pkg::QCNT_W'(cmw_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == cmw_pkg::QPTR_W'(cmw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == cmw_pkg::QPTR_W'(cmw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/cmw_back.sv
// Back end: offset store, tick sequencer and pixel query lookup.
module cmw_back #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmw_pkg::cmd_t  cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  cmw_pkg::cfg_t  cfg_i,
  cmw_rsp_if.source      rsp_o
);

  localparam int unsigned IDX_W = $clog2(MAX_COLUMNS);
  localparam int unsigned CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned OFF_W = cmw_pkg::OFF_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_QRES = 4'b0010,
    ST_TRD  = 4'b0100,
    ST_TWR  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [CNT_W-1:0]                col_q, col_d;
  logic [cmw_pkg::TICK_W-1:0]      ticks_q, ticks_d;
  logic                            moved_q, moved_d;
  logic [cmw_pkg::ROW_W-1:0]       row_q, row_d;
  logic                            inrange_q, inrange_d;
  logic                            out_vld_q, out_vld_d;
  cmw_pkg::rsp_t                   out_q, out_d;

  logic signed [OFF_W-1:0]         mem [MAX_COLUMNS];
  logic signed [OFF_W-1:0]         rd_data_q;
  logic                            rd_en, wr_en;
  logic [IDX_W-1:0]                rd_addr, wr_addr;
  logic signed [OFF_W-1:0]         wr_data;

  logic [CNT_W-1:0]                n_cols;
  logic                            pop, last_col;
  logic signed [OFF_W-1:0]         height_s;
  logic signed [OFF_W-1:0]         adv_off;
  logic [OFF_W:0]                  grow_sum;
  logic                            adv_moved;
  logic [OFF_W-1:0]                q_depth;
  logic [OFF_W-1:0]                row_ext;

  assign n_cols = (32'(cfg_i.active_columns) > 32'(MAX_COLUMNS))
                ? CNT_W'(MAX_COLUMNS) : CNT_W'(cfg_i.active_columns);
  assign cmd_ready_o = (state_q == ST_IDLE) && (!out_vld_q || rsp_o.ready);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign last_col    = CNT_W'(col_q + 1'b1) == n_cols;
  assign height_s    = $signed({1'b0, cfg_i.screen_height});

  // one tick step of the column just read
  always_comb begin
    adv_off   = rd_data_q;
    adv_moved = 1'b0;
    grow_sum  = '0;
    if (rd_data_q < 0) begin
      adv_off   = rd_data_q + OFF_W'(1);
      adv_moved = 1'b1;
    end else if (rd_data_q < height_s) begin
      if (rd_data_q < OFF_W'(cmw_pkg::FAST_LIMIT)) begin
        grow_sum = {1'b0, rd_data_q} + {1'b0, rd_data_q} + (OFF_W + 1)'(1);
      end else begin
        grow_sum = {1'b0, rd_data_q} + (OFF_W + 1)'(cmw_pkg::SLOW_STEP);
      end
      adv_off   = (grow_sum >= {1'b0, height_s}) ? height_s : grow_sum[OFF_W-1:0];
      adv_moved = 1'b1;
    end
  end

  // query: negative or out-of-store offsets count as zero
  assign q_depth = (!inrange_q || rd_data_q[OFF_W-1]) ? '0 : rd_data_q;
  assign row_ext = {1'b0, row_q};

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    ticks_d   = ticks_q;
    moved_d   = moved_q;
    row_d     = row_q;
    inrange_d = inrange_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    out_d     = out_q;
    rd_en     = 1'b0;
    rd_addr   = col_q[IDX_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = col_q[IDX_W-1:0];
    wr_data   = adv_off;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          unique case (cmd_i.kind)
            cmw_pkg::REQ_SEED: begin
              wr_en     = cmd_i.col_ok;
              wr_addr   = IDX_W'(cmd_i.col);
              wr_data   = OFF_W'(cmd_i.seed_val);
              out_vld_d = 1'b1;
              out_d     = '0;
            end
            cmw_pkg::REQ_TICK: begin
              if (cmd_i.ticks == '0 || n_cols == '0) begin
                out_vld_d      = 1'b1;
                out_d          = '0;
                out_d.all_done = 1'b1;
              end else begin
                ticks_d = cmd_i.ticks;
                col_d   = '0;
                moved_d = 1'b0;
                state_d = ST_TRD;
              end
            end
            cmw_pkg::REQ_QUERY: begin
              rd_en     = 1'b1;
              rd_addr   = IDX_W'(cmd_i.col);
              row_d     = cmd_i.row;
              inrange_d = cmd_i.col_ok;
              state_d   = ST_QRES;
            end
            default: begin
              out_vld_d = 1'b1;
              out_d     = '0;
            end
          endcase
        end
      end
      ST_QRES: begin
        out_vld_d = 1'b1;
        out_d     = '0;
        if (row_ext < q_depth) begin
          out_d.use_end_frame = 1'b1;
          out_d.source_row    = row_q;
        end else begin
          out_d.source_row    = cmw_pkg::ROW_W'(row_ext - q_depth);
        end
        state_d = ST_IDLE;
      end
      ST_TRD: begin
        rd_en   = 1'b1;
        state_d = ST_TWR;
      end
      ST_TWR: begin
        wr_en   = adv_moved;
        moved_d = moved_q || adv_moved;
        state_d = ST_TRD;
        if (last_col) begin
          col_d = '0;
          if (ticks_q == cmw_pkg::TICK_W'(1)) begin
            out_vld_d      = 1'b1;
            out_d          = '0;
            out_d.all_done = !(moved_q || adv_moved);
            state_d        = ST_IDLE;
          end else begin
            ticks_d = ticks_q - 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      ticks_q   <= '0;
      moved_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      ticks_q   <= ticks_d;
      moved_q   <= moved_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    inrange_q <= inrange_d;
    out_q     <= out_d;
  end

  // offset store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.use_end_frame = out_q.use_end_frame;
  assign rsp_o.source_row    = out_q.source_row;
  assign rsp_o.all_done      = out_q.all_done;

endmodule

FILE: rtl/core/column_melt_wipe_engine_top.sv
// Top level of the column melt wipe engine: front end, queue, back end and APB registers.
//
// Keeps one signed drop offset per screen column for a melting screen wipe.
// Items arrive on req_i (valid/ready) and each gives exactly one result on
// rsp_o, in order. req_type 0 seeds a column from random_byte (column 0 first,
// then each later one walks from the last seed); 1 advances every active column
// tick_count times and reports all_done when nothing moved; 2 asks which frame
// and row a pixel at (column_index, row_index) shows; 3 does nothing and
// returns zeros. Fields that mean nothing for an item's type read as 0.
// The front end accepts and classifies items into a two-entry queue, so it
// keeps taking items while the back end is busy, until the queue is full. At
// the back end, seeds and no-op items go back to back, one per cycle while
// rsp_o is ready; a pixel query makes one registered read of the offset store;
// a tick item has the sequencer read a column, then write it back, one column
// at a time through the store, tick_count times over min(active_columns,
// MAX_COLUMNS) columns; with zero columns or ticks it answers without a sweep. The offset
// store has no reset: a column must be seeded before it is ticked or queried.
// Registers (APB, write only while the block is idle):
//   0x0 active_columns (9 bits, reset 160)  0x4 screen_height (10 bits, reset 200)
module column_melt_wipe_engine_top #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  cmw_req_if.sink                            req_i,
  cmw_rsp_if.source                          rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cmw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cmw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cmw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  cmw_pkg::cfg_t  cfg_q, cfg_d;
  cmw_pkg::cmd_t  front_cmd, back_cmd;
  logic           front_valid, front_ready;
  logic           back_valid, back_ready;
  logic           cfg_wr;

  // ---------------------------------------------------------------------------
  // APB register file; no wait states
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        cmw_pkg::REG_ACTIVE_COLUMNS: cfg_d.active_columns = pwdata[cmw_pkg::ACOL_W-1:0];
        cmw_pkg::REG_SCREEN_HEIGHT:  cfg_d.screen_height  = pwdata[cmw_pkg::HEIGHT_W-1:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cmw_pkg::REG_ACTIVE_COLUMNS: prdata = cmw_pkg::APB_DATA_W'(cfg_q.active_columns);
      cmw_pkg::REG_SCREEN_HEIGHT:  prdata = cmw_pkg::APB_DATA_W'(cfg_q.screen_height);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_columns <= cmw_pkg::ACTIVE_COLUMNS_RST;
      cfg_q.screen_height  <= cmw_pkg::SCREEN_HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: classifies items and keeps the seed walk
  // ---------------------------------------------------------------------------
  cmw_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  // Decoupling queue so the front can take items while a tick sweep runs
  cmw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // ---------------------------------------------------------------------------
  // Back end: offset store, tick sweep, queries and the result register
  // ---------------------------------------------------------------------------
  cmw_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cfg_i       (cfg_q),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: rtl/core/cmw_checker.sv
// Port-level checks of the column melt wipe engine, bound to its top level.
`include "assert_macros.svh"

module cmw_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic                       rsp_use_end_frame_i,
  input logic [cmw_pkg::ROW_W-1:0]  rsp_source_row_i,
  input logic                       rsp_all_done_i,
  input logic                       pready_i
);

  logic [7:0]                 pend_q, pend_d;
  logic                       rsp_stall;
  logic                       tick_done;
  logic                       qry_clear;
  logic [cmw_pkg::ROW_W+1:0]  rsp_bits;

  // items taken in and not yet answered
  assign pend_d = pend_q + 8'(req_valid_i && req_ready_i) - 8'(rsp_valid_i && rsp_ready_i);

  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign tick_done = rsp_valid_i && rsp_all_done_i;
  assign qry_clear = !rsp_use_end_frame_i && rsp_source_row_i == '0;
  assign rsp_bits  = {rsp_use_end_frame_i, rsp_source_row_i, rsp_all_done_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `ASSERT_RST(a_rsp_hold, rsp_stall |=> rsp_valid_i, "result dropped while stalled")
  `ASSERT_RST(a_rsp_stable, rsp_stall |=> $stable(rsp_bits), "result changed while stalled")
  `ASSERT_RST(a_tick_fields, tick_done |-> qry_clear, "tick result carries query fields")
  `ASSERT_RST(a_no_spurious, rsp_valid_i |-> pend_q != '0, "result without an outstanding item")
  `ASSERT_ALWAYS(a_pready, pready_i, "APB wait state seen")

endmodule

bind column_melt_wipe_engine_top cmw_checker u_cmw_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_use_end_frame_i (rsp_o.use_end_frame),
  .rsp_source_row_i    (rsp_o.source_row),
  .rsp_all_done_i      (rsp_o.all_done),
  .pready_i            (pready)
);
